[design/loc_pkg.sv]
package loc_pkg;
  localparam int unsigned MaxClipSteps = 4;
  localparam int unsigned CoordW = 32;
  localparam int unsigned CodeW = 5;
  localparam int unsigned TW = 31;
  localparam int unsigned DivSteps = 30;

  localparam logic [CodeW-1:0] OcLeft   = 5'b00010;
  localparam logic [CodeW-1:0] OcRight  = 5'b00100;
  localparam logic [CodeW-1:0] OcBottom = 5'b01000;
  localparam logic [CodeW-1:0] OcTop    = 5'b10000;

  localparam logic [2:0] RegEnable = 3'd0;
  localparam logic [2:0] RegMinX   = 3'd1;
  localparam logic [2:0] RegMaxX   = 3'd2;
  localparam logic [2:0] RegMinY   = 3'd3;
  localparam logic [2:0] RegMaxY   = 3'd4;

  typedef struct packed {
    logic load;
    logic setup;
    logic div_start;
    logic lerp_start;
    logic commit;
  } loc_cmd_t;

  typedef struct packed {
    logic [CodeW-1:0] code_a;
    logic [CodeW-1:0] code_b;
    logic             div_done;
    logic             lerp_done;
  } loc_sts_t;

  function automatic logic [CodeW-1:0] region(
    input logic signed [CoordW-1:0] x, input logic signed [CoordW-1:0] y,
    input logic signed [CoordW-1:0] mnx, input logic signed [CoordW-1:0] mxx,
    input logic signed [CoordW-1:0] mny, input logic signed [CoordW-1:0] mxy);
    logic [CodeW-1:0] c;
    c = '0;
    if (x < mnx) c = c | OcLeft;
    else if (x > mxx) c = c | OcRight;
    if (y < mny) c = c | OcTop;
    else if (y > mxy) c = c | OcBottom;
    return c;
  endfunction
endpackage

[design/loc_ctrl.sv]
module loc_ctrl import loc_pkg::*; #(
  parameter int unsigned MAX_CLIP_STEPS = MaxClipSteps
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  logic     enable_i,
  input  loc_sts_t sts_i,
  output loc_cmd_t cmd_o,
  output logic     rej_o
);
  typedef enum logic [2:0] {
    StIdle, StCheck, StSetup, StDiv, StLerp, StCommit, StOut
  } state_e;

  localparam int unsigned StepW = $clog2(MAX_CLIP_STEPS + 1);

  state_e           state_q;
  logic [StepW-1:0] step_q;
  logic             rej_q;
  logic             en_q;

  assign in_stall  = (state_q != StIdle);
  assign out_valid = (state_q == StOut);
  assign rej_o     = rej_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load       = (state_q == StIdle) && in_valid;
    cmd_o.setup      = (state_q == StSetup);
    cmd_o.div_start  = (state_q == StSetup);
    cmd_o.lerp_start = (state_q == StDiv) && sts_i.div_done;
    cmd_o.commit     = (state_q == StCommit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      rej_q   <= 1'b0;
      en_q    <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: if (in_valid) begin
          step_q  <= '0;
          rej_q   <= 1'b0;
          en_q    <= enable_i;
          state_q <= StCheck;
        end
        StCheck: begin
          if (!en_q || (sts_i.code_a | sts_i.code_b) == '0) begin
            rej_q   <= 1'b0;
            state_q <= StOut;
          end else if ((sts_i.code_a & sts_i.code_b) != '0 ||
                       step_q >= StepW'(MAX_CLIP_STEPS)) begin
            rej_q   <= 1'b1;
            state_q <= StOut;
          end else begin
            state_q <= StSetup;
          end
        end
        StSetup: state_q <= StDiv;
        StDiv:   if (sts_i.div_done) state_q <= StLerp;
        StLerp:  if (sts_i.lerp_done) state_q <= StCommit;
        StCommit: begin
          step_q  <= step_q + 1'b1;
          state_q <= StCheck;
        end
        StOut: if (!out_stall) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

[design/loc_datapath.sv]
module loc_datapath import loc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  loc_cmd_t                 cmd_i,
  output loc_sts_t                 sts_o,
  input  logic signed [CoordW-1:0] min_x_i,
  input  logic signed [CoordW-1:0] max_x_i,
  input  logic signed [CoordW-1:0] min_y_i,
  input  logic signed [CoordW-1:0] max_y_i,
  input  logic signed [CoordW-1:0] a_x_i,
  input  logic signed [CoordW-1:0] a_y_i,
  input  logic signed [CoordW-1:0] a_z_i,
  input  logic signed [CoordW-1:0] b_x_i,
  input  logic signed [CoordW-1:0] b_y_i,
  input  logic signed [CoordW-1:0] b_z_i,
  output logic signed [CoordW-1:0] pa_x_o,
  output logic signed [CoordW-1:0] pa_y_o,
  output logic signed [CoordW-1:0] pa_z_o,
  output logic signed [CoordW-1:0] pb_x_o,
  output logic signed [CoordW-1:0] pb_y_o,
  output logic signed [CoordW-1:0] pb_z_o
);
  localparam int unsigned DW = CoordW + 1;
  localparam int unsigned CntW = $clog2(DivSteps + 1);

  logic signed [CoordW-1:0] pa_q [3];
  logic signed [CoordW-1:0] pb_q [3];
  logic signed [CoordW-1:0] np_q [3];
  logic [CodeW-1:0] ca_q, cb_q;
  logic             mv_q, axis_q;
  logic signed [CoordW-1:0] bound_q;

  logic [DW-1:0]   den_q;
  logic [DW:0]     rem_q;
  logic [TW-1:0]   quo_q;
  logic [CntW-1:0] dcnt_q;
  logic            dbusy_q, ddone_q;

  logic [1:0]      lk_q;
  logic            lbusy_q, ldone_q;
  logic [DW+TW-1:0] prod_q;
  logic            lneg_q, lmul_q;

  logic signed [DW-1:0] na, nb, num_s, den_s;
  logic [DW-1:0]        num_m, den_m, num_c;
  logic             mvn;
  logic             axn;
  logic [1:0]       ai;
  logic [CoordW-1:0] bnd;
  logic [DW:0]      rsh, rsub;
  logic signed [DW-1:0] dk;
  logic [DW-1:0]    dk_m;
  logic [DW+TW-1:0] rounded;
  logic signed [DW-1:0] lres;
  logic [CodeW-1:0] cm;

  always_comb begin
    mvn = (cb_q > ca_q);
    cm  = mvn ? cb_q : ca_q;
    axn = ((cm & (OcTop | OcBottom)) != '0);
    ai  = {1'b0, axn};
    if ((cm & OcTop) != '0) bnd = min_y_i;
    else if ((cm & OcBottom) != '0) bnd = max_y_i;
    else if ((cm & OcLeft) != '0) bnd = min_x_i;
    else bnd = max_x_i;
  end

  always_comb begin
    na    = DW'($signed(pa_q[ai]));
    nb    = DW'($signed(pb_q[ai]));
    num_s = DW'($signed(bnd)) - na;
    den_s = nb - na;
    num_m = num_s[DW-1] ? DW'(-num_s) : num_s;
    den_m = den_s[DW-1] ? DW'(-den_s) : den_s;
    num_c = (num_m > den_m) ? den_m : num_m;
    rsh   = {rem_q[DW-1:0], 1'b0};
    rsub  = rsh - {1'b0, den_q};
    dk    = DW'($signed(pb_q[lk_q])) - DW'($signed(pa_q[lk_q]));
    dk_m  = dk[DW-1] ? DW'(-dk) : dk;
    rounded = prod_q + (DW+TW)'(1 << (TW - 2));
    lres  = lneg_q ? DW'($signed(pa_q[lk_q])) - DW'(rounded >> (TW - 1))
                   : DW'($signed(pa_q[lk_q])) + DW'(rounded >> (TW - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      ddone_q <= 1'b0;
      lbusy_q <= 1'b0;
      ldone_q <= 1'b0;
      lmul_q  <= 1'b0;
    end else begin
      ddone_q <= 1'b0;
      ldone_q <= 1'b0;
      if (cmd_i.div_start) begin
        dbusy_q <= 1'b1;
      end else if (dbusy_q) begin
        if (dcnt_q == CntW'(DivSteps - 1)) begin
          dbusy_q <= 1'b0;
          ddone_q <= 1'b1;
        end
      end
      if (cmd_i.lerp_start) begin
        lbusy_q <= 1'b1;
        lmul_q  <= 1'b0;
      end else if (lbusy_q) begin
        lmul_q <= ~lmul_q;
        if (lmul_q && lk_q == 2'd2) begin
          lbusy_q <= 1'b0;
          ldone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pa_q[0] <= a_x_i; pa_q[1] <= a_y_i; pa_q[2] <= a_z_i;
      pb_q[0] <= b_x_i; pb_q[1] <= b_y_i; pb_q[2] <= b_z_i;
      ca_q <= region(a_x_i, a_y_i, min_x_i, max_x_i, min_y_i, max_y_i);
      cb_q <= region(b_x_i, b_y_i, min_x_i, max_x_i, min_y_i, max_y_i);
    end
    if (cmd_i.setup) begin
      mv_q    <= mvn;
      axis_q  <= axn;
      bound_q <= bnd;
    end
    // integer bit of the fraction first, then one bit per cycle
    if (cmd_i.div_start) begin
      den_q  <= (den_m == '0) ? DW'(1) : den_m;
      dcnt_q <= '0;
      if (den_m == '0) begin
        rem_q <= '0;
        quo_q <= '0;
      end else if (num_c == den_m) begin
        rem_q <= '0;
        quo_q <= TW'(1);
      end else begin
        rem_q <= {1'b0, num_c};
        quo_q <= '0;
      end
    end else if (dbusy_q) begin
      dcnt_q <= dcnt_q + 1'b1;
      if (!rsub[DW]) begin
        rem_q <= rsub;
        quo_q <= {quo_q[TW-2:0], 1'b1};
      end else begin
        rem_q <= rsh;
        quo_q <= {quo_q[TW-2:0], 1'b0};
      end
    end
    if (cmd_i.lerp_start) begin
      lk_q <= 2'd0;
    end else if (lbusy_q) begin
      if (!lmul_q) begin
        prod_q <= (DW+TW)'(dk_m) * (DW+TW)'(quo_q);
        lneg_q <= dk[DW-1];
      end else begin
        np_q[lk_q] <= (lk_q == {1'b0, axis_q}) ? bound_q : lres[CoordW-1:0];
        lk_q <= lk_q + 1'b1;
      end
    end
    if (cmd_i.commit) begin
      if (mv_q) begin
        pb_q <= np_q;
        cb_q <= region(np_q[0], np_q[1], min_x_i, max_x_i, min_y_i, max_y_i);
      end else begin
        pa_q <= np_q;
        ca_q <= region(np_q[0], np_q[1], min_x_i, max_x_i, min_y_i, max_y_i);
      end
    end
  end

  assign sts_o.code_a    = ca_q;
  assign sts_o.code_b    = cb_q;
  assign sts_o.div_done  = ddone_q;
  assign sts_o.lerp_done = ldone_q;
  assign pa_x_o = pa_q[0];
  assign pa_y_o = pa_q[1];
  assign pa_z_o = pa_q[2];
  assign pb_x_o = pb_q[0];
  assign pb_y_o = pb_q[1];
  assign pb_z_o = pb_q[2];
endmodule

[design/line_outcode_clipper.sv]
// channel   signals                              direction
// request   in_valid, in_stall, a_*_i, b_*_i     in
// result    out_valid, out_stall, rejected_o...  out
// config    cfg_we_i, cfg_idx_i, cfg_data_i      in
// one segment at a time: idle, check and output states, plus for each clip move:
// setup, the divider (integer bit at setup, then one quotient bit per step),
// three multiplies on one shared multiplier, commit and recheck;
// at most four moves by default, else rejected; reset clears config to zero
// the result is held while out_stall is high; no new request until taken
module line_outcode_clipper import loc_pkg::*; #(
  parameter int unsigned MAX_CLIP_STEPS = MaxClipSteps
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [CoordW-1:0] a_x_i,
  input  logic signed [CoordW-1:0] a_y_i,
  input  logic signed [CoordW-1:0] a_z_i,
  input  logic signed [CoordW-1:0] b_x_i,
  input  logic signed [CoordW-1:0] b_y_i,
  input  logic signed [CoordW-1:0] b_z_i,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     rejected_o,
  output logic signed [CoordW-1:0] out_a_x_o,
  output logic signed [CoordW-1:0] out_a_y_o,
  output logic signed [CoordW-1:0] out_a_z_o,
  output logic signed [CoordW-1:0] out_b_x_o,
  output logic signed [CoordW-1:0] out_b_y_o,
  output logic signed [CoordW-1:0] out_b_z_o,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [CoordW-1:0]        cfg_data_i
);
  logic                     en_q;
  logic signed [CoordW-1:0] mnx_q, mxx_q, mny_q, mxy_q;
  loc_cmd_t cmd;
  loc_sts_t sts;
  logic rej;
  logic signed [CoordW-1:0] pax, pay, paz, pbx, pby, pbz;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0; mnx_q <= '0; mxx_q <= '0; mny_q <= '0; mxy_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegEnable: en_q  <= cfg_data_i[0];
        RegMinX:   mnx_q <= cfg_data_i;
        RegMaxX:   mxx_q <= cfg_data_i;
        RegMinY:   mny_q <= cfg_data_i;
        RegMaxY:   mxy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  loc_ctrl #(.MAX_CLIP_STEPS(MAX_CLIP_STEPS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .enable_i(en_q), .sts_i(sts), .cmd_o(cmd), .rej_o(rej)
  );

  loc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .min_x_i(mnx_q), .max_x_i(mxx_q), .min_y_i(mny_q), .max_y_i(mxy_q),
    .a_x_i, .a_y_i, .a_z_i, .b_x_i, .b_y_i, .b_z_i,
    .pa_x_o(pax), .pa_y_o(pay), .pa_z_o(paz),
    .pb_x_o(pbx), .pb_y_o(pby), .pb_z_o(pbz)
  );

  assign rejected_o = rej;
  assign out_a_x_o = rej ? '0 : pax;
  assign out_a_y_o = rej ? '0 : pay;
  assign out_a_z_o = rej ? '0 : paz;
  assign out_b_x_o = rej ? '0 : pbx;
  assign out_b_y_o = rej ? '0 : pby;
  assign out_b_z_o = rej ? '0 : pbz;
endmodule

[design/loc_checker.sv]
module loc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic rejected_o,
  input logic [31:0] out_a_x_o
);
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("request taken while result pending");
  a_rej_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && rejected_o) |-> out_a_x_o == '0) else $error("rejected not zero");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> out_valid && $stable(rejected_o))
    else $error("result dropped");
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !in_stall) |=> in_stall) else $error("not busy after request");
endmodule

bind line_outcode_clipper loc_checker u_chk (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
  .rejected_o, .out_a_x_o
);

[bench/line_outcode_clipper_checker.sv]
module line_outcode_clipper_checker import loc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [CoordW-1:0] a_x_i,
  input  logic signed [CoordW-1:0] a_y_i,
  input  logic signed [CoordW-1:0] a_z_i,
  input  logic signed [CoordW-1:0] b_x_i,
  input  logic signed [CoordW-1:0] b_y_i,
  input  logic signed [CoordW-1:0] b_z_i,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     rejected_o,
  input  logic signed [CoordW-1:0] out_a_x_o,
  input  logic signed [CoordW-1:0] out_a_y_o,
  input  logic signed [CoordW-1:0] out_a_z_o,
  input  logic signed [CoordW-1:0] out_b_x_o,
  input  logic signed [CoordW-1:0] out_b_y_o,
  input  logic signed [CoordW-1:0] out_b_z_o,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [CoordW-1:0]        cfg_data_i,
  output int                       fail_count_o,
  output int                       waiting_o
);
  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic   rej;
    coord_t ax, ay, az, bx, by, bz;
  } clipped_seg_t;

  logic   win_en;
  coord_t win_min_x, win_max_x, win_min_y, win_max_y;
  clipped_seg_t clipped_q[$];
  int     fails;

  assign fail_count_o = fails;
  assign waiting_o = clipped_q.size();

  function automatic logic [CodeW-1:0] outcode(coord_t x, coord_t y);
    logic [CodeW-1:0] c;
    c = '0;
    if (x < win_min_x) c |= OcLeft;
    else if (x > win_max_x) c |= OcRight;
    if (y < win_min_y) c |= OcTop;
    else if (y > win_max_y) c |= OcBottom;
    return c;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned crossing_frac(coord_t bnd, coord_t ac, coord_t bc);
    longint unsigned n, d;
    n = magnitude(longint'(bnd) - longint'(ac));
    d = magnitude(longint'(bc) - longint'(ac));
    if (d == 0) return 0;
    if (n > d) n = d;
    return (n << 30) / d;
  endfunction

  function automatic coord_t interp(coord_t a, coord_t b, longint unsigned t);
    longint d;
    longint unsigned m;
    d = longint'(b) - longint'(a);
    m = (magnitude(d) * t + (64'd1 << 29)) >> 30;
    return d < 0 ? coord_t'(longint'(a) - longint'(m)) : coord_t'(longint'(a) + longint'(m));
  endfunction

  function automatic clipped_seg_t clip_segment(coord_t ia[3], coord_t ib[3]);
    coord_t p[2][3];
    coord_t np[3];
    logic [CodeW-1:0] code[2];
    logic [CodeW-1:0] oc;
    logic rej;
    int mv, axis, steps;
    coord_t bnd;
    longint unsigned t;
    clipped_seg_t r;
    p[0] = ia;
    p[1] = ib;
    rej = 1'b0;
    if (win_en) begin
      code[0] = outcode(p[0][0], p[0][1]);
      code[1] = outcode(p[1][0], p[1][1]);
      steps = 0;
      forever begin
        if ((code[0] | code[1]) == '0) break;
        if ((code[0] & code[1]) != '0 || steps >= MaxClipSteps) begin
          rej = 1'b1;
          break;
        end
        mv = code[1] > code[0] ? 1 : 0;
        oc = code[mv];
        if (oc & OcTop) begin
          axis = 1; bnd = win_min_y;
        end else if (oc & OcBottom) begin
          axis = 1; bnd = win_max_y;
        end else if (oc & OcLeft) begin
          axis = 0; bnd = win_min_x;
        end else begin
          axis = 0; bnd = win_max_x;
        end
        t = crossing_frac(bnd, p[0][axis], p[1][axis]);
        for (int k = 0; k < 3; k++)
          np[k] = (k == axis) ? bnd : interp(p[0][k], p[1][k], t);
        p[mv] = np;
        code[mv] = outcode(p[mv][0], p[mv][1]);
        steps++;
      end
    end
    if (rej) begin
      r = '0;
      r.rej = 1'b1;
    end else begin
      r = {1'b0, p[0][0], p[0][1], p[0][2], p[1][0], p[1][1], p[1][2]};
    end
    return r;
  endfunction

  task automatic report(string field, logic [CoordW-1:0] got, logic [CoordW-1:0] want);
    $display("mismatch %s: got %h want %h", field, got, want);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    clipped_seg_t e;
    if (!rst_ni) begin
      win_en <= 1'b0;
      win_min_x <= '0;
      win_max_x <= '0;
      win_min_y <= '0;
      win_max_y <= '0;
      fails = 0;
      clipped_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegEnable: win_en <= cfg_data_i[0];
          RegMinX:   win_min_x <= cfg_data_i;
          RegMaxX:   win_max_x <= cfg_data_i;
          RegMinY:   win_min_y <= cfg_data_i;
          RegMaxY:   win_max_y <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        clipped_q.insert(clipped_q.size(),
                         clip_segment('{a_x_i, a_y_i, a_z_i}, '{b_x_i, b_y_i, b_z_i}));
      if (out_valid && !out_stall) begin
        if (clipped_q.size() == 0) begin
          $display("mismatch: result with no request pending");
          fails++;
        end else begin
          e = clipped_q.pop_front();
          if (rejected_o !== e.rej) report("rejected", rejected_o, e.rej);
          if (out_a_x_o !== e.ax) report("out_a_x", out_a_x_o, e.ax);
          if (out_a_y_o !== e.ay) report("out_a_y", out_a_y_o, e.ay);
          if (out_a_z_o !== e.az) report("out_a_z", out_a_z_o, e.az);
          if (out_b_x_o !== e.bx) report("out_b_x", out_b_x_o, e.bx);
          if (out_b_y_o !== e.by) report("out_b_y", out_b_y_o, e.by);
          if (out_b_z_o !== e.bz) report("out_b_z", out_b_z_o, e.bz);
        end
      end
    end
  end
endmodule

[bench/line_outcode_clipper_test.sv]
module line_outcode_clipper_test import loc_pkg::*;;
  typedef logic signed [CoordW-1:0] coord_t;

  localparam coord_t CMin = 32'sh8000_0000;
  localparam coord_t CMax = 32'sh7fff_ffff;
  localparam int StallLimit = 5000;

  logic clk_i, rst_ni;
  logic in_valid, in_stall, out_valid, out_stall, rejected_o;
  coord_t a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i;
  coord_t out_a_x_o, out_a_y_o, out_a_z_o, out_b_x_o, out_b_y_o, out_b_z_o;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [CoordW-1:0] cfg_data_i;
  int fail_count, waiting;
  logic no_gaps, long_hold;
  coord_t lo_x, hi_x, lo_y, hi_y;

  line_outcode_clipper dut (.*);
  line_outcode_clipper_checker checker_i (.*, .fail_count_o(fail_count), .waiting_o(waiting));

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver side
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 4);
      if (long_hold) begin
        n = 400;
        long_hold = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid && !out_stall));
    end
  end

  // watchdog
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we_i) idle = 0;
      else idle++;
      if (idle >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_segment(coord_t ax, coord_t ay, coord_t az, coord_t bx, coord_t by,
                              coord_t bz);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    a_x_i <= ax; a_y_i <= ay; a_z_i <= az;
    b_x_i <= bx; b_y_i <= by; b_z_i <= bz;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CoordW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_window(logic en, coord_t mnx, coord_t mxx, coord_t mny, coord_t mxy);
    write_reg(RegEnable, {31'd0, en});
    write_reg(RegMinX, mnx);
    write_reg(RegMaxX, mxx);
    write_reg(RegMinY, mny);
    write_reg(RegMaxY, mxy);
    cfg_we_i <= 1'b0;
    lo_x = mnx; hi_x = mxx; lo_y = mny; hi_y = mxy;
  endtask

  function automatic coord_t near(coord_t lo, coord_t hi);
    longint l, h, w, v;
    l = lo < hi ? lo : hi;
    h = lo < hi ? hi : lo;
    w = h - l + 1;
    if ($urandom_range(0, 4) == 0) return coord_t'($urandom);
    v = l - w + longint'({$urandom, $urandom} % (3 * w + 1));
    if (v < longint'(CMin)) v = CMin;
    if (v > longint'(CMax)) v = CMax;
    return coord_t'(v);
  endfunction

  task automatic send_near();
    send_segment(near(lo_x, hi_x), near(lo_y, hi_y), coord_t'($urandom),
                 near(lo_x, hi_x), near(lo_y, hi_y), coord_t'($urandom));
  endtask

  function automatic coord_t rand_bound();
    case ($urandom_range(0, 3))
      0: return CMin + coord_t'($urandom_range(0, 1000));
      1: return CMax - coord_t'($urandom_range(0, 1000));
      2: return coord_t'($urandom);
      default: return coord_t'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
    endcase
  endfunction

  initial begin
    coord_t p100, m100, p50, m50;
    coord_t b0, b1, b2, b3;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegEnable;
    cfg_data_i = '0;
    {a_x_i, a_y_i, a_z_i, b_x_i, b_y_i, b_z_i} = '0;
    no_gaps = 1'b0;
    long_hold = 1'b0;
    p100 = 100 << 16; m100 = -(100 << 16); p50 = 50 << 16; m50 = -(50 << 16);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass-through with reset config, then explicitly disabled
    send_segment(CMin, CMax, -1, CMax, CMin, 0);
    drain();
    set_window(1'b0, m100, p100, m50, p50);
    send_segment(CMax, CMax, CMax, CMin, CMin, CMin);
    send_segment(p100 * 3, 0, 5, m100 * 3, 0, 7);
    drain();

    set_window(1'b1, m100, p100, m50, p50);
    send_segment(0, 0, 0, 1 << 16, 1 << 16, 1 << 16);
    send_segment(m100 * 2, 0, 0, m100 * 3, 10, 0);
    send_segment(m100 * 2, 0, 0, 0, 0, CMax);
    send_segment(0, 0, CMin, p100 * 2, 5, CMax);
    send_segment(0, m50 * 3, 0, 0, 0, 1 << 20);
    send_segment(7, p50 * 3, 0, 3, -9, -(1 << 20));
    send_segment(m100 * 2, m50 * 2, 0, p100 * 2, p50 * 2, 1000);
    send_segment(p100 * 2, m50 * 2, 3, m100 * 2, p50 * 2, -3);
    send_segment(m100 * 2, 0, 0, 0, m50 * 3, 0);
    send_segment(CMin, CMin, CMin, CMax, CMax, CMax);
    send_segment(CMax, CMin, 0, CMin, CMax, 0);
    send_segment(p100 * 2, p50 * 2, 1, p100 * 2, p50 * 2, 1);
    send_segment(m100 * 2, 0, 0, 0, p50 * 2, 0);
    drain();
    set_window(1'b1, p100, m100, p50, m50);
    send_segment(0, 0, 0, 5, 5, 5);
    send_segment(CMin, CMin, 1, CMax, CMax, 2);
    drain();
    set_window(1'b1, CMin, CMax, CMin, CMax);
    send_segment(CMin, CMax, 0, CMax, CMin, 0);
    drain();
    set_window(1'b1, CMax, CMax, CMin, CMin);
    send_segment(CMin, CMax, 9, CMax, CMin, -9);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      b0 = rand_bound(); b1 = rand_bound(); b2 = rand_bound(); b3 = rand_bound();
      if (ph % 3 != 2) begin
        if (b0 > b1) {b0, b1} = {b1, b0};
        if (b2 > b3) {b2, b3} = {b3, b2};
      end
      set_window(ph != 4, b0, b1, b2, b3);
      no_gaps = (ph == 5);
      for (int i = 0; i < 120; i++) begin
        if (ph == 3 && i == 10) long_hold = 1'b1;
        if (ph == 6 && i == 60) drain();
        send_near();
      end
      drain();
    end
    no_gaps = 1'b0;
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
